// ----- rtl/core/servo_pwm_pulse_decoder_unit_defines.svh -----
// Assertion macros used by the servo pulse decoder checker.
`ifndef SERVO_PWM_PULSE_DECODER_UNIT_DEFINES_SVH
`define SERVO_PWM_PULSE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, quiet in reset.
`define SPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet in reset.
`define SPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/spd_pkg.sv -----
// Types and constants of the servo PWM pulse decoder.
package spd_pkg;

  // Acceptance window for a pulse
  localparam logic [15:0] PulseLoUs  = 16'd500;
  localparam logic [15:0] PulseHiUs  = 16'd2500;
  localparam logic [15:0] PeriodLoUs = 16'd10000;
  localparam logic [15:0] PeriodHiUs = 16'd30000;
  localparam logic [1:0]  GoodNeeded = 2'd3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned PosW     = 20;

  localparam logic [CfgIdxW-1:0] CfgTimeoutMs   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinPulseUs  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPulseUs  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinPosMdeg  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxPosMdeg  = 3'd4;

  localparam logic [15:0]     RstTimeoutMs  = 16'd100;
  localparam logic [15:0]     RstMinPulseUs = 16'd1000;
  localparam logic [15:0]     RstMaxPulseUs = 16'd2000;
  localparam logic [PosW-1:0] RstMinPosMdeg = 20'hEA070;  // -90000
  localparam logic [PosW-1:0] RstMaxPosMdeg = 20'h15F90;  //  90000

  // Quotient bits of the position divider; |quotient| never exceeds 2^20
  localparam int unsigned QuotBits = 21;

  // One decoded item handed from the front to the back
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] period;
    logic        valid;
  } spd_item_t;

  // Position mapping settings
  typedef struct packed {
    logic [15:0]     min_pulse;
    logic [15:0]     max_pulse;
    logic [PosW-1:0] min_pos;
    logic [PosW-1:0] max_pos;
  } spd_map_cfg_t;

endpackage

// ----- rtl/core/spd_front.sv -----
// Front end: edge pairing, pulse qualification and timeout tracking.
module spd_front import spd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] timeout_ms_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] edge_time_i,
  input  logic [31:0] now_ms_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output spd_item_t   push_item_o
);

  logic        expect_fall_q, expect_fall_d;
  logic        rise_seen_q, rise_seen_d;
  logic [15:0] rise_stamp_q, rise_stamp_d;
  logic [15:0] meas_period_q, meas_period_d;
  logic [1:0]  good_cnt_q, good_cnt_d;
  logic [15:0] held_width_q, held_width_d;
  logic [15:0] held_period_q, held_period_d;
  logic [31:0] last_good_q, last_good_d;
  logic        valid_q, valid_d;

  logic [15:0] width;
  logic [31:0] elapsed;
  logic        pulse_ok;
  logic        accept;

  assign accept       = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  assign width    = edge_time_i - rise_stamp_q;
  assign elapsed  = now_ms_i - last_good_q;
  assign pulse_ok = rise_seen_q && (width >= PulseLoUs) && (width <= PulseHiUs) &&
                    (meas_period_q >= PeriodLoUs) && (meas_period_q <= PeriodHiUs);

  // Next state for the item on the inputs
  always_comb begin
    expect_fall_d = expect_fall_q;
    rise_seen_d   = rise_seen_q;
    rise_stamp_d  = rise_stamp_q;
    meas_period_d = meas_period_q;
    good_cnt_d    = good_cnt_q;
    held_width_d  = held_width_q;
    held_period_d = held_period_q;
    last_good_d   = last_good_q;
    valid_d       = valid_q;
    if (!kind_i) begin
      if (!expect_fall_q) begin
        // rising edge: period from previous rise
        rise_stamp_d = edge_time_i;
        if (rise_seen_q) begin
          meas_period_d = edge_time_i - rise_stamp_q;
        end
        rise_seen_d   = 1'b1;
        expect_fall_d = 1'b1;
      end else begin
        // falling edge: qualify pulse
        if (pulse_ok) begin
          held_width_d  = width;
          held_period_d = meas_period_q;
          last_good_d   = now_ms_i;
          good_cnt_d    = (good_cnt_q == GoodNeeded) ? good_cnt_q : good_cnt_q + 2'd1;
          valid_d       = (good_cnt_d == GoodNeeded);
        end else begin
          good_cnt_d = '0;
          valid_d    = 1'b0;
        end
        expect_fall_d = 1'b0;
      end
    end else if (elapsed > {16'd0, timeout_ms_i}) begin
      good_cnt_d = '0;
      valid_d    = 1'b0;
    end
  end

  assign push_item_o.width  = held_width_d;
  assign push_item_o.period = held_period_d;
  assign push_item_o.valid  = valid_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_fall_q <= 1'b0;
      rise_seen_q   <= 1'b0;
      rise_stamp_q  <= '0;
      meas_period_q <= '0;
      good_cnt_q    <= '0;
      held_width_q  <= '0;
      held_period_q <= '0;
      last_good_q   <= '0;
      valid_q       <= 1'b0;
    end else if (accept) begin
      expect_fall_q <= expect_fall_d;
      rise_seen_q   <= rise_seen_d;
      rise_stamp_q  <= rise_stamp_d;
      meas_period_q <= meas_period_d;
      good_cnt_q    <= good_cnt_d;
      held_width_q  <= held_width_d;
      held_period_q <= held_period_d;
      last_good_q   <= last_good_d;
      valid_q       <= valid_d;
    end
  end

endmodule

// ----- rtl/core/spd_queue.sv -----
// Small FIFO decoupling the front from the position back end.
module spd_queue import spd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  spd_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output spd_item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  spd_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/spd_back.sv -----
// Back end: width-to-position mapping with a serial divider, output register.
module spd_back import spd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spd_map_cfg_t    map_cfg_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  spd_item_t       item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     pulse_width_us_o,
  output logic [15:0]     period_us_o,
  output logic            signal_valid_o,
  output logic [PosW-1:0] position_mdeg_o
);

  localparam int unsigned ProdW = 38;
  localparam int unsigned MagW  = 37;
  localparam int unsigned CntW  = $clog2(QuotBits);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]              state_q, state_d;
  spd_item_t               item_q;
  logic signed [16:0]      diff_q, span_q;
  logic signed [20:0]      dpos_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    neg_q;
  logic [15:0]             div_q;
  logic [15:0]             rem_q;
  logic [QuotBits-1:0]     quo_q;
  logic [CntW-1:0]         cnt_q;

  logic                    out_valid_q;
  logic [15:0]             out_width_q, out_period_q;
  logic                    out_sig_q;
  logic [PosW-1:0]         out_pos_q;

  logic [15:0]             p_lo, p_clamp;
  logic signed [16:0]      diff, span;
  logic signed [20:0]      dpos;
  logic [ProdW-1:0]        mag;
  logic [16:0]             trial;
  logic                    ge;
  logic signed [QuotBits:0] quo_s;
  logic signed [QuotBits:0] pos_sum;
  logic                    out_load;

  // Clamp and span of the incoming item
  assign p_lo    = (item_i.width < map_cfg_i.min_pulse) ? map_cfg_i.min_pulse : item_i.width;
  assign p_clamp = (p_lo > map_cfg_i.max_pulse) ? map_cfg_i.max_pulse : p_lo;
  assign diff    = $signed({1'b0, p_clamp}) - $signed({1'b0, map_cfg_i.min_pulse});
  assign span    = $signed({1'b0, map_cfg_i.max_pulse}) - $signed({1'b0, map_cfg_i.min_pulse});
  assign dpos    = $signed({map_cfg_i.max_pos[PosW-1], map_cfg_i.max_pos})
                 - $signed({map_cfg_i.min_pos[PosW-1], map_cfg_i.min_pos});

  // Divider step
  assign mag   = prod_q[ProdW-1] ? 38'(-prod_q) : 38'(prod_q);
  assign trial = {rem_q, quo_q[QuotBits-1]};
  assign ge    = (trial >= {1'b0, div_q});

  // Final position
  assign quo_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign pos_sum = $signed({{(QuotBits + 1 - PosW){map_cfg_i.min_pos[PosW-1]}},
                            map_cfg_i.min_pos}) + quo_s;

  assign item_ready_o = (state_q == StIdle);
  assign out_load     = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          state_d = (!item_i.valid || span == '0) ? StDone : StMul;
        end
      end
      StMul:  state_d = StPrep;
      StPrep: state_d = StDiv;
      StDiv: begin
        if (cnt_q == CntW'(QuotBits - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        item_q <= item_i;
        diff_q <= diff;
        span_q <= span;
        dpos_q <= dpos;
        quo_q  <= '0;
        neg_q  <= 1'b0;
      end
      StMul: begin
        prod_q <= diff_q * dpos_q;
        neg_q  <= diff_q[16] ^ dpos_q[20] ^ span_q[16];
        div_q  <= span_q[16] ? 16'(-span_q) : span_q[15:0];
      end
      StPrep: begin
        rem_q <= mag[MagW-1:QuotBits];
        quo_q <= mag[QuotBits-1:0];
        cnt_q <= '0;
      end
      StDiv: begin
        rem_q <= ge ? 16'(trial - {1'b0, div_q}) : trial[15:0];
        quo_q <= {quo_q[QuotBits-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_width_q  <= item_q.width;
      out_period_q <= item_q.period;
      out_sig_q    <= item_q.valid;
      out_pos_q    <= item_q.valid ? pos_sum[PosW-1:0] : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pulse_width_us_o = out_width_q;
  assign period_us_o      = out_period_q;
  assign signal_valid_o   = out_sig_q;
  assign position_mdeg_o  = out_pos_q;

endmodule

// ----- rtl/core/servo_pwm_pulse_decoder_unit.sv -----
// Servo PWM pulse decoder: top level with configuration registers.
// Decodes RC servo pulses from 16-bit microsecond edge stamps (rising then falling) and
// tick items, giving one result per item: held width and period, the valid flag and the
// position in millidegrees (0 while not valid). The front takes one item per cycle while
// the queue has room, into a QueueDepth-entry queue. The back end works one item at a
// time: it takes the next only once the last result is in the output register, where
// results wait while the queue keeps filling. For a valid signal with a non-zero pulse
// span it does a multiply, a magnitude and a 21-step restoring divider, one quotient bit
// per cycle. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i and is to
// change only while no item is in flight; indexes above four are ignored.
module servo_pwm_pulse_decoder_unit import spd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [15:0]         edge_time_i,
  input  logic [31:0]         now_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         pulse_width_us_o,
  output logic [15:0]         period_us_o,
  output logic                signal_valid_o,
  output logic [PosW-1:0]     position_mdeg_o
);

  logic [15:0]  timeout_q;
  spd_map_cfg_t map_cfg_q;

  logic         push_valid, push_ready, pop_valid, pop_ready;
  spd_item_t    push_item, pop_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q           <= RstTimeoutMs;
      map_cfg_q.min_pulse <= RstMinPulseUs;
      map_cfg_q.max_pulse <= RstMaxPulseUs;
      map_cfg_q.min_pos   <= RstMinPosMdeg;
      map_cfg_q.max_pos   <= RstMaxPosMdeg;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTimeoutMs:  timeout_q           <= cfg_wdata_i[15:0];
        CfgMinPulseUs: map_cfg_q.min_pulse <= cfg_wdata_i[15:0];
        CfgMaxPulseUs: map_cfg_q.max_pulse <= cfg_wdata_i[15:0];
        CfgMinPosMdeg: map_cfg_q.min_pos   <= cfg_wdata_i;
        CfgMaxPosMdeg: map_cfg_q.max_pos   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  spd_front u_front (
    .clk_i,
    .rst_ni,
    .timeout_ms_i (timeout_q),
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .edge_time_i,
    .now_ms_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  spd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  spd_back u_back (
    .clk_i,
    .rst_ni,
    .map_cfg_i    (map_cfg_q),
    .item_valid_i (pop_valid),
    .item_ready_o (pop_ready),
    .item_i       (pop_item),
    .out_valid_o,
    .out_ready_i,
    .pulse_width_us_o,
    .period_us_o,
    .signal_valid_o,
    .position_mdeg_o
  );

endmodule

// ----- rtl/core/spd_checker.sv -----
// Port-level checker for the servo PWM pulse decoder, bound to the top level.
`include "servo_pwm_pulse_decoder_unit_defines.svh"

module spd_checker import spd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [15:0]         pulse_width_us_o,
  input logic [15:0]         period_us_o,
  input logic                signal_valid_o,
  input logic [PosW-1:0]     position_mdeg_o
);

  // A stalled result holds
  `SPD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(position_mdeg_o) && $stable(pulse_width_us_o), "result changed while stalled")

  // No signal means centre-less zero position
  `SPD_ASSERT_IMP(a_pos_zero, out_valid_o && !signal_valid_o, position_mdeg_o == '0, "position not zero while signal invalid")

  // A valid signal only ever reports in-window pulses
  `SPD_ASSERT_IMP(a_window, out_valid_o && signal_valid_o, pulse_width_us_o >= PulseLoUs && pulse_width_us_o <= PulseHiUs && period_us_o >= PeriodLoUs && period_us_o <= PeriodHiUs, "valid signal with out-of-window pulse")

  // Width and period are held together
  `SPD_ASSERT_IMP(a_pair, out_valid_o && pulse_width_us_o != '0, period_us_o >= PeriodLoUs, "held width without held period")

endmodule

bind servo_pwm_pulse_decoder_unit spd_checker u_spd_checker (.*);
